// ----- design/assert_macros.svh -----
// Assertion macros shared by the lexer modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every rising clock edge outside reset.
`define TLEX_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error(msg);

// Condition that must never be seen outside reset.
`define TLEX_ASSERT_NEVER(label, clk, rst, cond, msg) \
   `TLEX_ASSERT(label, clk, rst, !(cond), msg)

`endif

// ----- design/tlex_pkg.sv -----
// Types and character constants shared by the token lexer modules.
package tlex_pkg;

   // One result item: a token character or an end-only marker.
   typedef struct packed {
      logic       has_char;
      logic [7:0] char_value;
      logic [2:0] kind;
      logic       last;
   } result_type;

   localparam logic [2:0] KIND_QUOTED  = 3'd0;
   localparam logic [2:0] KIND_BRACKET = 3'd1;
   localparam logic [2:0] KIND_IDENT   = 3'd2;
   localparam logic [2:0] KIND_NUMBER  = 3'd3;
   localparam logic [2:0] KIND_SINGLE  = 3'd4;
   localparam logic [2:0] KIND_WORD    = 3'd5;

   localparam logic [7:0] CH_NUL        = 8'h00;
   localparam logic [7:0] CH_SPACE      = 8'h20;
   localparam logic [7:0] CH_SLASH      = 8'h2F;
   localparam logic [7:0] CH_STAR       = 8'h2A;
   localparam logic [7:0] CH_NEWLINE    = 8'h0A;
   localparam logic [7:0] CH_QUOTE      = 8'h22;
   localparam logic [7:0] CH_LBRACKET   = 8'h5B;
   localparam logic [7:0] CH_RBRACKET   = 8'h5D;
   localparam logic [7:0] CH_UNDERSCORE = 8'h5F;
   localparam logic [7:0] CH_MINUS      = 8'h2D;
   localparam logic [7:0] CH_DOT        = 8'h2E;
   localparam logic [7:0] CH_LOWER_E    = 8'h65;
   localparam logic [7:0] CH_UPPER_E    = 8'h45;
   localparam logic [7:0] CH_LOWER_X    = 8'h78;

endpackage

// ----- design/tlex_core.sv -----
// Lexer state registers and the per-byte transition that yields up to two results.
module tlex_core
   import tlex_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        accept,
   input  logic [7:0]  byte_value,
   input  logic        end_of_input,
   input  logic        word_mode,
   output logic [1:0]  push_count,
   output result_type  push_data [2]
);

`include "assert_macros.svh"

   typedef enum logic [3:0] {
      ST_IDLE    = 4'd0,
      ST_LINE    = 4'd1,
      ST_BLOCK   = 4'd2,
      ST_QUOTED  = 4'd3,
      ST_BRACKET = 4'd4,
      ST_IDENT   = 4'd5,
      ST_NUMBER  = 4'd6,
      ST_WORD    = 4'd7
   } state_type;

   typedef struct packed {
      logic       emit;
      result_type res;
      state_type  state;
      logic       slash;
   } scan_type;

   state_type state_ff, state_in;
   logic      slash_ff, slash_in;
   logic      star_ff, star_in;
   logic [1:0] count;
   result_type res [2];
   scan_type   scan;

   function automatic result_type mk(logic has, logic [7:0] ch, logic [2:0] kind, logic last);
      result_type r;
      r.has_char   = has;
      r.char_value = has ? ch : CH_NUL;
      r.kind       = kind;
      r.last       = last;
      return r;
   endfunction

   function automatic logic is_alpha(logic [7:0] c);
      return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A);
   endfunction

   function automatic logic is_digit(logic [7:0] c);
      return c >= 8'h30 && c <= 8'h39;
   endfunction

   // Start of a token from idle; the byte is known to be nonzero.
   function automatic scan_type scan_idle(logic [7:0] c, logic mode);
      scan_type s;
      s.emit  = 1'b0;
      s.res   = mk(1'b1, c, KIND_SINGLE, 1'b1);
      s.state = ST_IDLE;
      s.slash = 1'b0;
      if (c <= CH_SPACE) begin
         s.emit = 1'b0;
      end else if (c == CH_SLASH) begin
         s.slash = 1'b1;
      end else if (c == CH_QUOTE) begin
         s.state = ST_QUOTED;
      end else if (mode) begin
         s.emit  = 1'b1;
         s.res   = mk(1'b1, c, KIND_WORD, 1'b0);
         s.state = ST_WORD;
      end else if (c == CH_LBRACKET) begin
         s.emit  = 1'b1;
         s.res   = mk(1'b1, c, KIND_BRACKET, 1'b0);
         s.state = ST_BRACKET;
      end else if (is_alpha(c) || c == CH_UNDERSCORE) begin
         s.emit  = 1'b1;
         s.res   = mk(1'b1, c, KIND_IDENT, 1'b0);
         s.state = ST_IDENT;
      end else if (is_digit(c) || c == CH_MINUS) begin
         s.emit  = 1'b1;
         s.res   = mk(1'b1, c, KIND_NUMBER, 1'b0);
         s.state = ST_NUMBER;
      end else begin
         s.emit = 1'b1;
      end
      return s;
   endfunction

   always_comb begin
      state_in = state_ff;
      slash_in = slash_ff;
      star_in  = star_ff;
      count    = 2'd0;
      res[0]   = mk(1'b0, CH_NUL, KIND_QUOTED, 1'b0);
      res[1]   = mk(1'b0, CH_NUL, KIND_QUOTED, 1'b0);
      scan     = scan_idle(byte_value, word_mode);

      if (end_of_input || byte_value == CH_NUL) begin
         // A held slash only exists between tokens, so it and an open
         // token never need flushing together except in word mode.
         if (slash_ff) begin
            if (word_mode) begin
               res[0] = mk(1'b1, CH_SLASH, KIND_WORD, 1'b0);
               res[1] = mk(1'b0, CH_NUL, KIND_WORD, 1'b1);
               count  = 2'd2;
            end else begin
               res[0] = mk(1'b1, CH_SLASH, KIND_SINGLE, 1'b1);
               count  = 2'd1;
            end
         end else begin
            case (state_ff)
               ST_QUOTED: begin
                  res[0] = mk(1'b0, CH_NUL, KIND_QUOTED, 1'b1);
                  count  = 2'd1;
               end
               ST_BRACKET: begin
                  res[0] = mk(1'b0, CH_NUL, KIND_BRACKET, 1'b1);
                  count  = 2'd1;
               end
               ST_IDENT: begin
                  res[0] = mk(1'b0, CH_NUL, KIND_IDENT, 1'b1);
                  count  = 2'd1;
               end
               ST_NUMBER: begin
                  res[0] = mk(1'b0, CH_NUL, KIND_NUMBER, 1'b1);
                  count  = 2'd1;
               end
               ST_WORD: begin
                  res[0] = mk(1'b0, CH_NUL, KIND_WORD, 1'b1);
                  count  = 2'd1;
               end
               default: begin
                  count = 2'd0;
               end
            endcase
         end
         state_in = ST_IDLE;
         slash_in = 1'b0;
         star_in  = 1'b0;
      end else begin
         case (state_ff)
            ST_LINE: begin
               if (byte_value == CH_NEWLINE) begin
                  state_in = ST_IDLE;
               end
            end
            ST_BLOCK: begin
               if (star_ff && byte_value == CH_SLASH) begin
                  state_in = ST_IDLE;
                  star_in  = 1'b0;
               end else begin
                  star_in = (byte_value == CH_STAR);
               end
            end
            ST_QUOTED: begin
               count = 2'd1;
               if (byte_value == CH_QUOTE) begin
                  res[0]   = mk(1'b0, CH_NUL, KIND_QUOTED, 1'b1);
                  state_in = ST_IDLE;
               end else begin
                  res[0] = mk(1'b1, byte_value, KIND_QUOTED, 1'b0);
               end
            end
            ST_BRACKET: begin
               count = 2'd1;
               if (byte_value == CH_RBRACKET) begin
                  res[0]   = mk(1'b1, byte_value, KIND_BRACKET, 1'b1);
                  state_in = ST_IDLE;
               end else begin
                  res[0] = mk(1'b1, byte_value, KIND_BRACKET, 1'b0);
               end
            end
            ST_IDENT: begin
               if (is_alpha(byte_value) || is_digit(byte_value)
                   || byte_value == CH_UNDERSCORE) begin
                  res[0] = mk(1'b1, byte_value, KIND_IDENT, 1'b0);
                  count  = 2'd1;
               end else begin
                  // Foreign byte: close the token and rescan the byte.
                  res[0]   = mk(1'b0, CH_NUL, KIND_IDENT, 1'b1);
                  res[1]   = scan.res;
                  count    = scan.emit ? 2'd2 : 2'd1;
                  state_in = scan.state;
                  slash_in = scan.slash;
               end
            end
            ST_NUMBER: begin
               if (is_digit(byte_value) || byte_value == CH_DOT
                   || byte_value == CH_LOWER_E || byte_value == CH_UPPER_E
                   || byte_value == CH_LOWER_X || byte_value == CH_MINUS) begin
                  res[0] = mk(1'b1, byte_value, KIND_NUMBER, 1'b0);
                  count  = 2'd1;
               end else begin
                  res[0]   = mk(1'b0, CH_NUL, KIND_NUMBER, 1'b1);
                  res[1]   = scan.res;
                  count    = scan.emit ? 2'd2 : 2'd1;
                  state_in = scan.state;
                  slash_in = scan.slash;
               end
            end
            ST_WORD: begin
               count = 2'd1;
               if (byte_value > CH_SPACE) begin
                  res[0] = mk(1'b1, byte_value, KIND_WORD, 1'b0);
               end else begin
                  res[0]   = mk(1'b0, CH_NUL, KIND_WORD, 1'b1);
                  state_in = ST_IDLE;
               end
            end
            default: begin
               state_in = ST_IDLE;
               if (slash_ff && byte_value == CH_SLASH) begin
                  slash_in = 1'b0;
                  state_in = ST_LINE;
               end else if (slash_ff && byte_value == CH_STAR) begin
                  slash_in = 1'b0;
                  state_in = ST_BLOCK;
                  star_in  = 1'b0;
               end else if (slash_ff && word_mode) begin
                  // The held slash opens a word; this byte continues or ends it.
                  slash_in = 1'b0;
                  res[0]   = mk(1'b1, CH_SLASH, KIND_WORD, 1'b0);
                  count    = 2'd2;
                  if (byte_value > CH_SPACE) begin
                     res[1]   = mk(1'b1, byte_value, KIND_WORD, 1'b0);
                     state_in = ST_WORD;
                  end else begin
                     res[1] = mk(1'b0, CH_NUL, KIND_WORD, 1'b1);
                  end
               end else if (slash_ff) begin
                  res[0]   = mk(1'b1, CH_SLASH, KIND_SINGLE, 1'b1);
                  res[1]   = scan.res;
                  count    = scan.emit ? 2'd2 : 2'd1;
                  state_in = scan.state;
                  slash_in = scan.slash;
               end else begin
                  res[0]   = scan.res;
                  count    = scan.emit ? 2'd1 : 2'd0;
                  state_in = scan.state;
                  slash_in = scan.slash;
               end
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         slash_ff <= 1'b0;
         star_ff  <= 1'b0;
      end else if (accept) begin
         state_ff <= state_in;
         slash_ff <= slash_in;
         star_ff  <= star_in;
      end
   end

   assign push_count   = accept ? count : 2'd0;
   assign push_data[0] = res[0];
   assign push_data[1] = res[1];

   `TLEX_ASSERT_NEVER(a_slash_only_idle, clock, reset, slash_ff && state_ff != ST_IDLE,
      "held slash outside the idle state")
   `TLEX_ASSERT_NEVER(a_star_only_block, clock, reset, star_ff && state_ff != ST_BLOCK,
      "star flag set outside a block comment")
   `TLEX_ASSERT_NEVER(a_count_legal, clock, reset, count == 2'd3,
      "more than two results for one item")

endmodule

// ----- design/tlex_queue.sv -----
// Result queue: up to two results in per cycle, one out while out_ready.
module tlex_queue
   import tlex_pkg::*;
#(
   parameter int DEPTH = 4
)
(
   input  logic        clock,
   input  logic        reset,
   input  logic [1:0]  push_count,
   input  result_type  push_data [2],
   output logic        space_ok,
   output logic        out_valid,
   input  logic        out_ready,
   output result_type  out_data
);

`include "assert_macros.svh"

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);

   result_type       entries_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [PTR_W-1:0] wr_next1, wr_next2;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             pop;

   always_comb begin
      pop      = out_valid && out_ready;
      wr_next1 = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + PTR_W'(1);
      wr_next2 = (wr_next1 == LAST_PTR) ? '0 : wr_next1 + PTR_W'(1);
      case (push_count)
         2'd1:    wr_ptr_in = wr_next1;
         2'd2:    wr_ptr_in = wr_next2;
         default: wr_ptr_in = wr_ptr_ff;
      endcase
      rd_ptr_in = rd_ptr_ff;
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      count_in = count_ff + CNT_W'(push_count) - CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_count != 2'd0) begin
         entries_ff[wr_ptr_ff] <= push_data[0];
      end
      if (push_count == 2'd2) begin
         entries_ff[wr_next1] <= push_data[1];
      end
   end

   assign space_ok  = count_ff <= CNT_W'(DEPTH - 2);
   assign out_valid = count_ff != '0;
   assign out_data  = entries_ff[rd_ptr_ff];

   `TLEX_ASSERT(a_count_bound, clock, reset, count_ff <= CNT_W'(DEPTH),
      "result queue count beyond its depth")
   `TLEX_ASSERT(a_push_has_room, clock, reset,
      (push_count != 2'd0) |-> (count_ff <= CNT_W'(DEPTH - 2)),
      "results pushed without two free entries")
   `TLEX_ASSERT(a_pop_drains, clock, reset,
      (pop && push_count == 2'd0) |=> (count_ff == $past(count_ff) - CNT_W'(1)),
      "a lone pop did not lower the count")

endmodule

// ----- design/token_lexer_unit.sv -----
// Token lexer top level: mode register, lexer core and result queue.
// An item's first result is offered in the cycle after its acceptance if the queue is empty.
// Throughput: one item per cycle while results drain; items with two results fill the queue
// faster than it drains, so req_ready (two free entries) falls under a stall or a run of such items.
// Reset is synchronous and active high; it clears the mode, the lexer state and the queue.
module token_lexer_unit
   import tlex_pkg::*;
#(
   parameter int QUEUE_DEPTH = 4
)
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_byte_value,
   input  logic       req_end_of_input,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic       rsp_has_char,
   output logic [7:0] rsp_char_value,
   output logic [2:0] rsp_kind,
   output logic       rsp_last,
   input  logic       csr_write_enable,
   input  logic       csr_write_data
);

   // Mode register: 0 selects the full token classes, 1 selects quoted strings or
   // whitespace-delimited words. It is to be written only while idle; the block does not enforce this.
   logic       word_mode_ff;
   logic       accept;
   logic [1:0] push_count;
   result_type push_data [2];
   result_type out_data;

   always_ff @(posedge clock) begin
      if (reset) begin
         word_mode_ff <= 1'b0;
      end else if (csr_write_enable) begin
         word_mode_ff <= csr_write_data;
      end
   end

   // An item is taken whenever the queue can absorb the worst case of two
   // results, so the lexer state advances in the same cycle as the accept.
   assign accept = req_valid && req_ready;

   // The core holds the lexer state and computes every result of one byte
   // in a single short transition.
   tlex_core u_core (
      .clock        (clock),
      .reset        (reset),
      .accept       (accept),
      .byte_value   (req_byte_value),
      .end_of_input (req_end_of_input),
      .word_mode    (word_mode_ff),
      .push_count   (push_count),
      .push_data    (push_data)
   );

   // The queue registers the results and separates the two channels, so a
   // stalled consumer does not block input until the queue fills.
   tlex_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_count (push_count),
      .push_data  (push_data),
      .space_ok   (req_ready),
      .out_valid  (rsp_valid),
      .out_ready  (rsp_ready),
      .out_data   (out_data)
   );

   assign rsp_has_char   = out_data.has_char;
   assign rsp_char_value = out_data.char_value;
   assign rsp_kind       = out_data.kind;
   assign rsp_last       = out_data.last;

endmodule

// ----- dv/token_lexer_unit_tb.sv -----
// Self-checking testbench for the token lexer unit with a scoreboard that predicts every result.
`timescale 1ns / 1ps

module token_lexer_unit_tb;
   import tlex_pkg::*;

   localparam int HALF_PERIOD      = 4;
   // The longest span with no handshake in a correct run is the long receiver
   // hold below; the watchdog allows many times that before it gives up.
   localparam int WATCHDOG_LIMIT   = 2000;
   localparam int LONG_HOLD_CYCLES = 150;
   // Cycles to let pass once the last expected result has come, so that an
   // item which causes no result has surely been consumed by the lexer.
   localparam int SETTLE_CYCLES    = 6;
   localparam int RANDOM_PHASES    = 5;
   localparam int PHASE_TOKEN_ITEMS = 75;

   // Where the lexer stands between bytes.
   typedef enum logic [2:0] {
      SCAN_IDLE,
      SCAN_LINE,
      SCAN_BLOCK,
      SCAN_QUOTED,
      SCAN_BRACKET,
      SCAN_IDENT,
      SCAN_NUMBER,
      SCAN_WORD
   } scan_state_type;

   // The scoreboard keeps its own copy of the lexer state and the mode bit.
   // Every accepted item is run through the token predictor, which appends the
   // results it causes to the queue of expected token results; every result
   // that leaves the block is checked against the oldest entry of that queue.
   class lexer_scoreboard_type;
      bit             word_mode = 1'b0;
      scan_state_type scan = SCAN_IDLE;
      bit             slash_pending = 1'b0;
      bit             star_pending = 1'b0;
      result_type     expected_tokens[$];
      int             error_count = 0;

      function bit is_letter(logic [7:0] c);
         return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
      endfunction

      function bit is_digit(logic [7:0] c);
         return c >= "0" && c <= "9";
      endfunction

      function void push_token(bit has, logic [7:0] c, logic [2:0] kind, bit ends);
         result_type r;
         r.has_char   = has;
         r.char_value = has ? c : CH_NUL;
         r.kind       = kind;
         r.last       = ends;
         expected_tokens.push_back(r);
      endfunction

      // A slash that did not open a comment comes out under the current mode.
      function void release_slash();
         slash_pending = 1'b0;
         if (word_mode) begin
            push_token(1'b1, CH_SLASH, KIND_WORD, 1'b0);
            scan = SCAN_WORD;
         end else begin
            push_token(1'b1, CH_SLASH, KIND_SINGLE, 1'b1);
         end
      endfunction

      // Start of a new token from the idle state.
      function void start_token(logic [7:0] c);
         if (c <= CH_SPACE) begin
            // Whitespace between tokens is dropped.
         end else if (c == CH_SLASH) begin
            slash_pending = 1'b1;
         end else if (c == CH_QUOTE) begin
            scan = SCAN_QUOTED;
         end else if (word_mode) begin
            push_token(1'b1, c, KIND_WORD, 1'b0);
            scan = SCAN_WORD;
         end else if (c == CH_LBRACKET) begin
            push_token(1'b1, c, KIND_BRACKET, 1'b0);
            scan = SCAN_BRACKET;
         end else if (is_letter(c) || c == CH_UNDERSCORE) begin
            push_token(1'b1, c, KIND_IDENT, 1'b0);
            scan = SCAN_IDENT;
         end else if (is_digit(c) || c == CH_MINUS) begin
            push_token(1'b1, c, KIND_NUMBER, 1'b0);
            scan = SCAN_NUMBER;
         end else begin
            push_token(1'b1, c, KIND_SINGLE, 1'b1);
         end
      endfunction

      // Notes one accepted item and returns how many results it causes.
      function int take_byte(logic [7:0] c, logic eoi);
         int before_count;
         before_count = expected_tokens.size();
         if (eoi || c == CH_NUL) begin
            // End of text flushes a held slash, closes an open token and
            // drops an open comment.
            if (slash_pending) release_slash();
            case (scan)
               SCAN_QUOTED:  push_token(1'b0, CH_NUL, KIND_QUOTED, 1'b1);
               SCAN_BRACKET: push_token(1'b0, CH_NUL, KIND_BRACKET, 1'b1);
               SCAN_IDENT:   push_token(1'b0, CH_NUL, KIND_IDENT, 1'b1);
               SCAN_NUMBER:  push_token(1'b0, CH_NUL, KIND_NUMBER, 1'b1);
               SCAN_WORD:    push_token(1'b0, CH_NUL, KIND_WORD, 1'b1);
               default: ;
            endcase
            scan = SCAN_IDLE;
            star_pending = 1'b0;
         end else begin
            case (scan)
               SCAN_LINE: begin
                  if (c == CH_NEWLINE) scan = SCAN_IDLE;
               end
               SCAN_BLOCK: begin
                  if (star_pending && c == CH_SLASH) begin
                     scan = SCAN_IDLE;
                     star_pending = 1'b0;
                  end else begin
                     star_pending = (c == CH_STAR);
                  end
               end
               SCAN_QUOTED: begin
                  if (c == CH_QUOTE) begin
                     push_token(1'b0, CH_NUL, KIND_QUOTED, 1'b1);
                     scan = SCAN_IDLE;
                  end else begin
                     push_token(1'b1, c, KIND_QUOTED, 1'b0);
                  end
               end
               SCAN_BRACKET: begin
                  push_token(1'b1, c, KIND_BRACKET, c == CH_RBRACKET);
                  if (c == CH_RBRACKET) scan = SCAN_IDLE;
               end
               SCAN_IDENT: begin
                  if (is_letter(c) || is_digit(c) || c == CH_UNDERSCORE) begin
                     push_token(1'b1, c, KIND_IDENT, 1'b0);
                  end else begin
                     push_token(1'b0, CH_NUL, KIND_IDENT, 1'b1);
                     scan = SCAN_IDLE;
                     start_token(c);
                  end
               end
               SCAN_NUMBER: begin
                  if (is_digit(c) || c == CH_DOT || c == CH_LOWER_E || c == CH_UPPER_E ||
                      c == CH_LOWER_X || c == CH_MINUS) begin
                     push_token(1'b1, c, KIND_NUMBER, 1'b0);
                  end else begin
                     push_token(1'b0, CH_NUL, KIND_NUMBER, 1'b1);
                     scan = SCAN_IDLE;
                     start_token(c);
                  end
               end
               SCAN_WORD: begin
                  if (c > CH_SPACE) begin
                     push_token(1'b1, c, KIND_WORD, 1'b0);
                  end else begin
                     push_token(1'b0, CH_NUL, KIND_WORD, 1'b1);
                     scan = SCAN_IDLE;
                  end
               end
               default: begin
                  scan = SCAN_IDLE;
                  if (slash_pending && c == CH_SLASH) begin
                     slash_pending = 1'b0;
                     scan = SCAN_LINE;
                  end else if (slash_pending && c == CH_STAR) begin
                     slash_pending = 1'b0;
                     scan = SCAN_BLOCK;
                     star_pending = 1'b0;
                  end else begin
                     if (slash_pending) release_slash();
                     if (scan == SCAN_WORD) begin
                        // The released slash opened a word; this byte
                        // continues or ends it.
                        if (c > CH_SPACE) begin
                           push_token(1'b1, c, KIND_WORD, 1'b0);
                        end else begin
                           push_token(1'b0, CH_NUL, KIND_WORD, 1'b1);
                           scan = SCAN_IDLE;
                        end
                     end else begin
                        start_token(c);
                     end
                  end
               end
            endcase
         end
         return expected_tokens.size() - before_count;
      endfunction

      function void check_result(result_type seen);
         result_type want;
         if (expected_tokens.size() == 0) begin
            $error("unexpected result: has_char=%0d char_value=0x%02h kind=%0d last=%0d",
                   seen.has_char, seen.char_value, seen.kind, seen.last);
            error_count++;
            return;
         end
         want = expected_tokens.pop_front();
         if (seen.has_char !== want.has_char) begin
            $error("has_char: expected %0d, got %0d", want.has_char, seen.has_char);
            error_count++;
         end
         if (seen.char_value !== want.char_value) begin
            $error("char_value: expected 0x%02h, got 0x%02h", want.char_value, seen.char_value);
            error_count++;
         end
         if (seen.kind !== want.kind) begin
            $error("kind: expected %0d, got %0d", want.kind, seen.kind);
            error_count++;
         end
         if (seen.last !== want.last) begin
            $error("last: expected %0d, got %0d", want.last, seen.last);
            error_count++;
         end
      endfunction

      function int pending();
         return expected_tokens.size();
      endfunction
   endclass

   // Every input of the block starts at a known value.
   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_ready;
   logic [7:0] req_byte_value = 8'h00;
   logic       req_end_of_input = 1'b0;
   logic       rsp_valid;
   logic       rsp_ready = 1'b0;
   logic       rsp_has_char;
   logic [7:0] rsp_char_value;
   logic [2:0] rsp_kind;
   logic       rsp_last;
   logic       csr_write_enable = 1'b0;
   logic       csr_write_data = 1'b0;

   lexer_scoreboard_type sb = new;

   // Knobs shared between the stimulus and the result sink.
   bit tx_steady = 1'b0;          // sender offers items back to back
   bit rx_steady = 1'b0;          // receiver takes every result at once
   bit long_hold_request = 1'b0;  // asks the receiver for one long stall
   int token_items = 0;           // accepted items that caused at least one result
   int quiet_cycles = 0;

   token_lexer_unit dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_byte_value   (req_byte_value),
      .req_end_of_input (req_end_of_input),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_has_char     (rsp_has_char),
      .rsp_char_value   (rsp_char_value),
      .rsp_kind         (rsp_kind),
      .rsp_last         (rsp_last),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   always #(HALF_PERIOD) clock = ~clock;

   // Gap lengths: mostly none, otherwise a random gap that is now and then a long one.
   function automatic int pick_gap(bit steady);
      int roll;
      if (steady) return 0;
      roll = $urandom_range(0, 99);
      if (roll < 65) return 0;
      if (roll < 94) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   function automatic logic [7:0] pick_from(string set);
      return set[$urandom_range(0, set.len() - 1)];
   endfunction

   // A nonzero byte other than the one that would close the current construct.
   function automatic logic [7:0] pick_byte_except(logic [7:0] avoid);
      logic [7:0] b;
      do b = 8'($urandom_range(1, 255)); while (b == avoid);
      return b;
   endfunction

   // Offers one item after a random gap and holds it until the block takes it.
   // The payload is only changed once the previous item has been accepted,
   // so valid never drops while an item is waiting.
   task automatic send_item(input logic [7:0] byte_in, input logic eoi_in);
      int gap;
      gap = pick_gap(tx_steady);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_byte_value   <= byte_in;
      req_end_of_input <= eoi_in;
      do @(posedge clock); while (!req_ready);
      if (sb.take_byte(byte_in, eoi_in) > 0) token_items++;
   endtask

   task automatic send_text(input string text);
      for (int i = 0; i < text.len(); i++) send_item(text[i], 1'b0);
   endtask

   // End of text; the byte that rides along is ignored by the block.
   task automatic send_end();
      send_item(8'($urandom_range(0, 255)), 1'b1);
   endtask

   // Stops offering items until every expected result has come back, then lets
   // the lexer settle so that items with no result are out of the way too.
   task automatic wait_drained();
      req_valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // The mode register is only written while the block is drained.
   task automatic write_mode(input bit mode_value);
      csr_write_enable <= 1'b1;
      csr_write_data   <= mode_value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      sb.word_mode = mode_value;
   endtask

   // One random piece of text. Most pieces are well-formed tokens or comments
   // with random content, so that every lexer state is reached; the rest are
   // stray bytes, bare slashes and ends of text that cut tokens short.
   task automatic send_fragment();
      int pick;
      int len;
      pick = $urandom_range(0, 99);
      if (pick < 14) begin
         send_item(pick_from("abcxyzABCXYZ_eE"), 1'b0);
         len = $urandom_range(0, 6);
         repeat (len) send_item(pick_from("azAZ09_e5xQ"), 1'b0);
      end else if (pick < 26) begin
         send_item(pick_from("0123456789-"), 1'b0);
         len = $urandom_range(0, 5);
         repeat (len) send_item(pick_from("0123456789.eEx-"), 1'b0);
      end else if (pick < 36) begin
         send_item(CH_QUOTE, 1'b0);
         len = $urandom_range(0, 8);
         repeat (len) send_item(pick_byte_except(CH_QUOTE), 1'b0);
         send_item(CH_QUOTE, 1'b0);
      end else if (pick < 44) begin
         send_item(CH_LBRACKET, 1'b0);
         len = $urandom_range(0, 6);
         repeat (len) send_item(pick_byte_except(CH_RBRACKET), 1'b0);
         send_item(CH_RBRACKET, 1'b0);
      end else if (pick < 51) begin
         send_text("//");
         len = $urandom_range(0, 8);
         repeat (len) send_item(pick_byte_except(CH_NEWLINE), 1'b0);
         send_item(CH_NEWLINE, 1'b0);
      end else if (pick < 58) begin
         // Random content may itself hold a closing pair; the predictor
         // follows whatever the bytes say.
         send_text("/*");
         len = $urandom_range(0, 8);
         repeat (len) send_item(pick_from("ab*/ *x"), 1'b0);
         send_text("*/");
      end else if (pick < 66) begin
         len = $urandom_range(1, 6);
         repeat (len) send_item(8'($urandom_range(33, 255)), 1'b0);
      end else if (pick < 74) begin
         send_item(8'($urandom_range(33, 255)), 1'b0);
      end else if (pick < 80) begin
         send_item(CH_SLASH, 1'b0);
         send_item(8'($urandom_range(1, 255)), 1'b0);
      end else if (pick < 87) begin
         if ($urandom_range(0, 1)) send_end();
         else send_item(CH_NUL, 1'b0);
      end else begin
         len = $urandom_range(1, 3);
         repeat (len) send_item(8'($urandom_range(0, 255)), 1'b0);
      end
      // Separate most pieces with whitespace, newlines among it.
      if ($urandom_range(0, 99) < 60) begin
         len = $urandom_range(1, 2);
         repeat (len) send_item(8'($urandom_range(1, 32)), 1'b0);
      end
   endtask

   // Result sink: checks each accepted result and decides rsp_ready for the
   // next edge. A long hold asked for by the stimulus is counted down here,
   // while the sender keeps offering items and the block backs up.
   initial begin : result_sink
      int stall_left;
      stall_left = 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && rsp_ready) begin
            sb.check_result(result_type'({rsp_has_char, rsp_char_value, rsp_kind, rsp_last}));
         end
         if (long_hold_request) begin
            long_hold_request = 1'b0;
            stall_left = LONG_HOLD_CYCLES;
         end
         if (stall_left > 0) begin
            rsp_ready <= 1'b0;
            stall_left--;
         end else if (rx_steady || $urandom_range(0, 99) < 70) begin
            rsp_ready <= 1'b1;
         end else begin
            rsp_ready <= 1'b0;
            stall_left = pick_gap(1'b0);
         end
      end
   end

   // Watchdog: too long without a handshake on either channel ends the run.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("tb: failure");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin : stimulus
      int phase_target;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      write_mode(1'b0);

      // Directed text in full token mode.
      send_text("ab+");          // identifier ended by a foreign byte: two results
      send_text("\"\"");         // empty quoted string gives just the end marker
      send_text("[]");           // bracket run kept with its brackets
      send_text("/9");           // held slash that opens no comment, then a number
      send_text("/*/*/");        // slash right after the opener does not close
      send_item(8'hFF, 1'b0);    // high byte is a single character
      send_text("-x");
      send_item(CH_NUL, 1'b0);   // byte zero acts as end of text
      send_text("c/");
      send_end();                // end of text flushes the held slash
      send_text("d");            // identifier left open across the mode change
      wait_drained();
      write_mode(1'b1);
      send_text("e ");           // the open identifier keeps its own kind
      send_item(CH_SLASH, 1'b0);
      send_end();                // held slash becomes a word, then ends it
      send_item(8'h80, 1'b0);
      send_item(8'h7F, 1'b0);
      send_item(CH_SPACE, 1'b0);

      // Random text in phases. Each phase starts with the sender waiting until
      // the block has drained, then sets the mode; phases end wherever the
      // text happens to be, so mode changes also land inside open tokens.
      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         wait_drained();
         write_mode(phase % 2 == 1);
         tx_steady = (phase == 2);
         rx_steady = (phase == 2);
         if (phase == 1) long_hold_request = 1'b1;
         phase_target = token_items + PHASE_TOKEN_ITEMS;
         while (token_items < phase_target) send_fragment();
      end

      send_end();
      wait_drained();
      if (sb.error_count == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
